FILE: rtl/urd_pkg.sv
// Shared types, constants and helper functions of the raster run decoder.
package urd_pkg;

  // Default size limits handed to the top-level parameters
  localparam int DEF_MAX_WIDTH  = 16384;
  localparam int DEF_MAX_HEIGHT = 16384;

  // Widths of the configuration fields
  localparam int DIM_W  = 15;
  localparam int PB_W   = 3;
  localparam int CFG_W  = 15;
  localparam int IDX_W  = 2;
  localparam int LIM_W  = 17;

  // Internal row and column counters (hold up to one past the largest dimension)
  localparam int CNT_W  = 16;

  // Result field widths
  localparam int ROW_W  = 14;
  localparam int RCNT_W = 9;
  localparam int COL_W  = 14;
  localparam int LEN_W  = 15;
  localparam int PIX_W  = 32;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_LINE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_PIXEL_BYTES = 2'd2;

  // Stream codes
  localparam logic [7:0] CODE_WHITE_FILL = 8'h80;
  localparam logic [7:0] CODE_REPEAT_MAX = 8'd127;

  // Reset values of the registers before clamping
  localparam logic [DIM_W-1:0] RST_LINE_WIDTH  = 15'd1024;
  localparam logic [DIM_W-1:0] RST_PAGE_HEIGHT = 15'd1024;
  localparam logic [PB_W-1:0]  RST_PIXEL_BYTES = 3'd3;

  typedef enum logic [1:0] {
    PH_REPEAT,
    PH_CODE,
    PH_PIXEL,
    PH_DONE
  } phase_t;

  // Clamped configuration as the decoder sees it
  typedef struct packed {
    logic [DIM_W-1:0] line_width;
    logic [DIM_W-1:0] page_height;
    logic [PB_W-1:0]  px_size;
  } cfg_t;

  // One pixel run
  typedef struct packed {
    logic [ROW_W-1:0]  row_first;
    logic [RCNT_W-1:0] row_count;
    logic [COL_W-1:0]  col_start;
    logic [LEN_W-1:0]  run_length;
    logic [PIX_W-1:0]  pixel_value;
    logic              line_end;
    logic              page_end;
  } run_t;

  // Clamp a line or page size to 1..lim
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [LIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if ({{(LIM_W-DIM_W){1'b0}}, v} > lim) begin
      r = lim[DIM_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Clamp bytes per pixel to 1..4
  function automatic logic [PB_W-1:0] clamp_pbytes(logic [PB_W-1:0] v);
    logic [PB_W-1:0] r;
    if (v == '0) begin
      r = 3'd1;
    end else if (v > 3'd4) begin
      r = 3'd4;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // White pixel: all ones over the active bytes
  function automatic logic [PIX_W-1:0] white_value(logic [PB_W-1:0] pb);
    logic [PIX_W-1:0] r;
    unique case (pb)
      3'd1:    r = 32'h0000_00FF;
      3'd2:    r = 32'h0000_FFFF;
      3'd3:    r = 32'h00FF_FFFF;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/urf_raster_run_decoder.sv
// Raster run decoder: compressed raster bytes in, clipped pixel runs out.
//
// Input channel: one stream byte per beat on in_valid/in_ready. Each line
// opens with a row repeat byte, then code bytes and pixel bytes follow.
// Output channel: one pixel run per beat on out_valid/out_ready, with its
// first row, row count, start column, length, value and line/page end flags.
// Configuration: cfg_write with cfg_index/cfg_data sets line width, page
// height and bytes per pixel; values are clamped when written. Write only
// while no byte is in flight.
// Path: the byte that completes a run is held in the input register, the
// run is decoded out of it, and the run is captured in the output register
// once that register has room.
// Throughput: one byte per cycle while the output register has room, set by
// the single decode step between the input register and the output register.
// Stall: while a run waits in the output register, bytes that give no run
// still flow; a byte that gives a run waits in the input register.
// Reset: synchronous; registers return to 1024 x 1024 at 3 bytes per pixel
// and the decoder waits for the first line's repeat byte. After the page
// end every further byte is accepted and dropped until reset.
module urf_raster_run_decoder #(
  parameter int MAX_WIDTH  = urd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = urd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [urd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [urd_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   stream_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [urd_pkg::ROW_W-1:0]    row_first,
  output logic [urd_pkg::RCNT_W-1:0]   row_count,
  output logic [urd_pkg::COL_W-1:0]    col_start,
  output logic [urd_pkg::LEN_W-1:0]    run_length,
  output logic [urd_pkg::PIX_W-1:0]    pixel_value,
  output logic                         line_end,
  output logic                         page_end
);
  import urd_pkg::*;

  cfg_t cfg;
  run_t res;
  run_t out_run;
  logic res_valid;
  logic out_free;

  urd_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  urd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res)
  );

  urd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_run   (out_run)
  );

  // Break the held run out onto the field ports
  assign row_first   = out_run.row_first;
  assign row_count   = out_run.row_count;
  assign col_start   = out_run.col_start;
  assign run_length  = out_run.run_length;
  assign pixel_value = out_run.pixel_value;
  assign line_end    = out_run.line_end;
  assign page_end    = out_run.page_end;

endmodule

FILE: rtl/urd_cfg.sv
// Configuration registers, clamped to their legal ranges as they are written.
module urd_cfg #(
  parameter int MAX_WIDTH  = urd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = urd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [urd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [urd_pkg::CFG_W-1:0]   cfg_data,
  output urd_pkg::cfg_t               cfg
);
  import urd_pkg::*;

  localparam logic [LIM_W-1:0] WLIM = LIM_W'(MAX_WIDTH);
  localparam logic [LIM_W-1:0] HLIM = LIM_W'(MAX_HEIGHT);

  // Store the clamped value of each register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width  <= clamp_dim(RST_LINE_WIDTH, WLIM);
      cfg.page_height <= clamp_dim(RST_PAGE_HEIGHT, HLIM);
      cfg.px_size     <= clamp_pbytes(RST_PIXEL_BYTES);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:  cfg.line_width  <= clamp_dim(cfg_data[DIM_W-1:0], WLIM);
        REG_PAGE_HEIGHT: cfg.page_height <= clamp_dim(cfg_data[DIM_W-1:0], HLIM);
        REG_PIXEL_BYTES: cfg.px_size     <= clamp_pbytes(cfg_data[PB_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/urd_decode.sv
// Input byte register, decoder state and run computation.
module urd_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  urd_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            stream_byte,
  input  logic                  out_free,
  output logic                  res_valid,
  output urd_pkg::run_t         res
);
  import urd_pkg::*;

  // Input stage
  logic [7:0] byte_q;
  logic       byte_valid;

  // Decoder state
  phase_t             phase, phase_next;
  logic [RCNT_W-1:0]  rows_pending, rows_pending_next;
  logic [CNT_W-1:0]   current_row, current_row_next;
  logic [CNT_W-1:0]   current_col, current_col_next;
  logic [7:0]         codes_left, codes_left_next;
  logic               run_is_repeat, run_is_repeat_next;
  logic [PIX_W-1:0]   pixel_accum, pixel_accum_next;
  logic [1:0]         pixel_byte_index, pixel_byte_index_next;

  // Run arithmetic
  logic               code_white, pixel_done, has_result, go;
  logic [1:0]         index_inc;
  logic [PIX_W-1:0]   accum_shift;
  logic [CNT_W-1:0]   w_ext, h_ext, rem, want, n, rows_left;
  logic [RCNT_W-1:0]  rows;
  logic [CNT_W-1:0]   col_sum, row_sum;
  logic               lend, pend;
  logic [7:0]         codes_dec;

  // Classify the byte in the input stage
  assign index_inc   = pixel_byte_index + 2'd1;
  assign accum_shift = {pixel_accum[PIX_W-9:0], byte_q};
  assign code_white  = (phase == PH_CODE) && (byte_q == CODE_WHITE_FILL);
  assign pixel_done  = (phase == PH_PIXEL) && (index_inc == cfg.px_size[1:0]);
  assign has_result  = code_white || pixel_done;
  assign go          = byte_valid && (!has_result || out_free);
  assign in_ready    = !byte_valid || go;
  assign res_valid   = go && has_result;
  assign codes_dec   = (codes_left != 8'd0) ? codes_left - 8'd1 : 8'd0;

  // Clip the run at the line end and the rows at the page end
  assign w_ext     = CNT_W'(cfg.line_width);
  assign h_ext     = CNT_W'(cfg.page_height);
  assign rem       = (current_col < w_ext) ? w_ext - current_col : CNT_W'(1);
  assign want      = run_is_repeat ? CNT_W'(codes_left) : CNT_W'(1);
  assign n         = (code_white || (rem <= want)) ? rem : want;
  assign rows_left = (current_row < h_ext) ? h_ext - current_row : CNT_W'(1);
  assign rows      = (CNT_W'(rows_pending) < rows_left) ? rows_pending
                                                       : rows_left[RCNT_W-1:0];
  assign col_sum   = current_col + n;
  assign row_sum   = current_row + CNT_W'(rows);
  assign lend      = (col_sum >= w_ext);
  assign pend      = lend && (row_sum >= h_ext);

  // Result fields
  always_comb begin
    res.row_first   = current_row[ROW_W-1:0];
    res.row_count   = rows;
    res.col_start   = current_col[COL_W-1:0];
    res.run_length  = n[LEN_W-1:0];
    res.pixel_value = pixel_done ? accum_shift : white_value(cfg.px_size);
    res.line_end    = lend;
    res.page_end    = pend;
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_REPEAT: phase_next = PH_CODE;
      PH_CODE: begin
        if (code_white) begin
          if (lend) phase_next = pend ? PH_DONE : PH_REPEAT;
        end else begin
          phase_next = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        if (pixel_done) begin
          priority if (lend) begin
            phase_next = pend ? PH_DONE : PH_REPEAT;
          end else if (run_is_repeat || (codes_dec == 8'd0)) begin
            phase_next = PH_CODE;
          end
        end
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_DONE;
    endcase
  end

  // Next counters and pixel assembly
  always_comb begin
    rows_pending_next     = rows_pending;
    current_row_next      = current_row;
    current_col_next      = current_col;
    codes_left_next       = codes_left;
    run_is_repeat_next    = run_is_repeat;
    pixel_accum_next      = pixel_accum;
    pixel_byte_index_next = pixel_byte_index;
    if (has_result) begin
      if (lend) begin
        current_col_next = '0;
        current_row_next = row_sum;
      end else begin
        current_col_next = col_sum;
      end
    end
    unique case (phase)
      PH_REPEAT: begin
        rows_pending_next = RCNT_W'(byte_q) + RCNT_W'(1);
        current_col_next  = '0;
      end
      PH_CODE: begin
        if (!code_white) begin
          if (byte_q <= CODE_REPEAT_MAX) begin
            run_is_repeat_next = 1'b1;
            codes_left_next    = byte_q + 8'd1;
          end else begin
            run_is_repeat_next = 1'b0;
            codes_left_next    = 8'd1 - byte_q;
          end
          pixel_accum_next      = '0;
          pixel_byte_index_next = '0;
        end
      end
      PH_PIXEL: begin
        if (pixel_done) begin
          pixel_accum_next      = '0;
          pixel_byte_index_next = '0;
          if (run_is_repeat || lend) codes_left_next = 8'd0;
          else                       codes_left_next = codes_dec;
        end else begin
          pixel_accum_next      = accum_shift;
          pixel_byte_index_next = index_inc;
        end
      end
      default: ;
    endcase
  end

  // Hold or advance the input byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid <= 1'b1;
    end else if (go) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_q <= stream_byte;
  end

  // Update decoder state once the byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_REPEAT;
      rows_pending     <= RCNT_W'(1);
      current_row      <= '0;
      current_col      <= '0;
      codes_left       <= '0;
      run_is_repeat    <= 1'b0;
      pixel_accum      <= '0;
      pixel_byte_index <= '0;
    end else if (go) begin
      phase            <= phase_next;
      rows_pending     <= rows_pending_next;
      current_row      <= current_row_next;
      current_col      <= current_col_next;
      codes_left       <= codes_left_next;
      run_is_repeat    <= run_is_repeat_next;
      pixel_accum      <= pixel_accum_next;
      pixel_byte_index <= pixel_byte_index_next;
    end
  end

`ifndef SYNTHESIS
  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("run loaded while output register is full");

  a_done_is_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |-> !has_result)
    else $error("run produced after page end");

  a_line_end_resets_col: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.line_end) |=> (current_col == '0))
    else $error("column not cleared after line end");

  a_rows_nonzero: assert property (@(posedge clk) disable iff (rst)
    rows_pending != '0)
    else $error("row repeat count is zero");

  a_page_end_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.page_end) |=> (phase == PH_DONE))
    else $error("decoder still active after page end");
`endif

endmodule

FILE: rtl/urd_out_reg.sv
// Output register that holds one run beat until the receiver takes it.
module urd_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  input  urd_pkg::run_t  res,
  output logic           out_free,
  output logic           out_valid,
  input  logic           out_ready,
  output urd_pkg::run_t  out_run
);
  import urd_pkg::*;

  assign out_free = !out_valid || out_ready;

  // Load a new beat or drop the one taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_run <= res;
  end

endmodule
